// ===== design/sdpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpq_pkg
// shared types and constants of the step/direction pulse queue
// ----------------------------------------------------------------------------
package sdpq_pkg;

    localparam int PERIOD_WIDTH = 17;
    localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 17'd5000;

    localparam int COUNT_WIDTH = 32;
    localparam int POS_OUT_WIDTH = 64;

    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // register word index, taken from paddr[2]
    localparam logic REG_STEP_PERIOD = 1'b0;

    localparam logic DIR_FORWARD = 1'b0;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_ABORT = 2'd2
    } action_t;

    typedef struct packed {
        action_t                action;
        logic                   direction;
        logic [COUNT_WIDTH-1:0] step_count;
        logic                   nfault_level;
    } item_t;

    typedef struct packed {
        logic                            step_pulse;
        logic                            dir_line;
        logic [COUNT_WIDTH-1:0]          pending_steps;
        logic signed [POS_OUT_WIDTH-1:0] net_position;
        logic                            fault;
    } result_t;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] period;
        logic                    restart;
    } cfg_t;

endpackage

// ===== design/step_dir_pulse_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_pulse_queue
// step/direction pulse generator with a queue of pending microsteps
// ----------------------------------------------------------------------------
// usage
//   s_* stream carries one request per item: s_tuser holds the action
//   (tick, move, abort), s_tdata the direction, step count and fault level
//   m_* stream returns exactly one result per request: step pulse, direction
//   line level, queued steps, signed net position and fault flag
//   the apb port holds the step period at byte address 0; a write of a new
//   value restarts the period phase, rewriting the same value does nothing
// timing
//   a request is held in the input register; its result is computed and
//   loaded into the output register, which drives m_tvalid, once the
//   output slot is free or draining; one request per cycle is sustained
//   while m_tready is high: the whole update is a single pass of a 17 bit
//   compare, a saturating add and a position increment or decrement
// reset and stalls
//   reset empties both registers, clears queue, phase and position, selects
//   forward and loads the default period of 5000 ticks
//   while m_tready is low a held result stays put; the input register still
//   takes one more request, after which s_tready drops until the output
//   drains
// ----------------------------------------------------------------------------
module step_dir_pulse_queue
#(
    parameter int PENDING_WIDTH  = 32,
    parameter int POSITION_WIDTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [39:0]                         s_tdata,   // direction, step_count[31:0], nfault_level, zero pad
    input  logic [1:0]                          s_tuser,   // action
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [103:0]                        m_tdata,   // step_pulse, dir_line, pending_steps[31:0],
                                                           // net_position[63:0], fault, zero pad
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdpq_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [sdpq_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [sdpq_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                pready
);

    sdpq_pkg::cfg_t    cfg;
    sdpq_pkg::item_t   in_item_reg;
    sdpq_pkg::item_t   in_item_next;
    logic              in_valid_reg;
    sdpq_pkg::result_t result;
    sdpq_pkg::result_t out_result_reg;
    logic              out_valid_reg;
    logic              s_fire;
    logic              advance;

    sdpq_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // unpack the incoming request
    assign in_item_next.action       = sdpq_pkg::action_t'(s_tuser);
    assign in_item_next.direction    = s_tdata[0];
    assign in_item_next.step_count   = s_tdata[32:1];
    assign in_item_next.nfault_level = s_tdata[33];

    // the held request moves on when the output slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    sdpq_step_engine
    #(
        .PENDING_WIDTH  (PENDING_WIDTH),
        .POSITION_WIDTH (POSITION_WIDTH)
    )
    u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= in_item_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_result_reg.fault,
                       out_result_reg.net_position,
                       out_result_reg.pending_steps,
                       out_result_reg.dir_line,
                       out_result_reg.step_pulse};

endmodule

// ===== design/sdpq_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpq_apb_regs
// apb register file holding the step period
// ----------------------------------------------------------------------------
module sdpq_apb_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sdpq_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [sdpq_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [sdpq_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,
    output sdpq_pkg::cfg_t                       cfg
);

    logic [sdpq_pkg::PERIOD_WIDTH-1:0] period_reg;
    logic [sdpq_pkg::PERIOD_WIDTH-1:0] period_next;
    logic                              wr_period;
    logic                              sel_period;

    assign pready      = 1'b1;
    assign sel_period  = (paddr[2] == sdpq_pkg::REG_STEP_PERIOD);
    assign period_next = pwdata[sdpq_pkg::PERIOD_WIDTH-1:0];
    assign wr_period   = psel && penable && pwrite && pready && sel_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= sdpq_pkg::PERIOD_RESET;
        end
        else if (wr_period)
        begin
            period_reg <= period_next;
        end
    end

    // a changed period restarts the phase counter at the write edge
    assign cfg.period  = period_reg;
    assign cfg.restart = wr_period && (period_next != period_reg);

    always_comb
    begin
        if (sel_period)
        begin
            prdata = sdpq_pkg::APB_DATA_WIDTH'(period_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

endmodule

// ===== design/sdpq_step_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpq_step_engine
// period counter, step queue, direction and position state
// ----------------------------------------------------------------------------
module sdpq_step_engine
#(
    parameter int PENDING_WIDTH  = 32,
    parameter int POSITION_WIDTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  sdpq_pkg::item_t  item,
    input  sdpq_pkg::cfg_t   cfg,
    output sdpq_pkg::result_t result
);

    localparam logic [PENDING_WIDTH-1:0] PENDING_MAX = {PENDING_WIDTH{1'b1}};

    logic [sdpq_pkg::PERIOD_WIDTH-1:0] period_counter_reg;
    logic [sdpq_pkg::PERIOD_WIDTH-1:0] period_counter_next;
    logic [PENDING_WIDTH-1:0]          pending_reg;
    logic [PENDING_WIDTH-1:0]          pending_next;
    logic                              direction_reg;
    logic                              direction_next;
    logic signed [POSITION_WIDTH-1:0]  net_reg;
    logic signed [POSITION_WIDTH-1:0]  net_next;

    logic [sdpq_pkg::PERIOD_WIDTH-1:0] period_eff;
    logic [sdpq_pkg::PERIOD_WIDTH-1:0] count_inc;
    logic                              period_hit;
    logic [PENDING_WIDTH-1:0]          move_base;
    logic [sdpq_pkg::COUNT_WIDTH:0]    move_sum;
    logic                              step_pulse;

    assign period_eff = (cfg.period == '0) ? sdpq_pkg::PERIOD_WIDTH'(1) : cfg.period;
    assign count_inc  = period_counter_reg + sdpq_pkg::PERIOD_WIDTH'(1);
    assign period_hit = (count_inc >= period_eff);

    // a reversal drops the queue before the new count is added
    assign move_base = (item.direction != direction_reg) ? '0 : pending_reg;
    assign move_sum  = (sdpq_pkg::COUNT_WIDTH+1)'(move_base)
                     + (sdpq_pkg::COUNT_WIDTH+1)'(item.step_count);

    always_comb
    begin
        period_counter_next = period_counter_reg;
        pending_next        = pending_reg;
        direction_next      = direction_reg;
        net_next            = net_reg;
        step_pulse          = 1'b0;
        unique case (item.action)
            sdpq_pkg::ACT_TICK:
            begin
                if (period_hit)
                begin
                    period_counter_next = '0;
                    if (pending_reg != '0)
                    begin
                        pending_next = pending_reg - PENDING_WIDTH'(1);
                        step_pulse   = 1'b1;
                        if (direction_reg == sdpq_pkg::DIR_FORWARD)
                        begin
                            net_next = net_reg + POSITION_WIDTH'(1);
                        end
                        else
                        begin
                            net_next = net_reg - POSITION_WIDTH'(1);
                        end
                    end
                end
                else
                begin
                    period_counter_next = count_inc;
                end
            end
            sdpq_pkg::ACT_MOVE:
            begin
                if (item.step_count != '0)
                begin
                    direction_next = item.direction;
                    if (move_sum >= (sdpq_pkg::COUNT_WIDTH+1)'(PENDING_MAX))
                    begin
                        pending_next = PENDING_MAX;
                    end
                    else
                    begin
                        pending_next = move_sum[PENDING_WIDTH-1:0];
                    end
                end
            end
            sdpq_pkg::ACT_ABORT:
            begin
                pending_next = '0;
            end
            default:
            begin
                // unused code reports the state only
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_counter_reg <= '0;
            pending_reg        <= '0;
            direction_reg      <= sdpq_pkg::DIR_FORWARD;
            net_reg            <= '0;
        end
        else
        begin
            if (cfg.restart)
            begin
                period_counter_reg <= '0;
            end
            else if (advance)
            begin
                period_counter_reg <= period_counter_next;
            end
            if (advance)
            begin
                pending_reg   <= pending_next;
                direction_reg <= direction_next;
                net_reg       <= net_next;
            end
        end
    end

    assign result.step_pulse    = step_pulse;
    assign result.dir_line      = (direction_next == sdpq_pkg::DIR_FORWARD);
    assign result.pending_steps = sdpq_pkg::COUNT_WIDTH'(pending_next);
    assign result.net_position  = sdpq_pkg::POS_OUT_WIDTH'(net_next);
    assign result.fault         = !item.nfault_level;

endmodule
